/* src/rsa_pkg.sv */
`timescale 1ns / 1ps
// shared types and codes for the rpn stack alu
// no dependencies

package rsa_pkg;

	// request codes carried on req_type
	typedef enum logic [2:0] {
		REQ_PUSH = 3'd0,
		REQ_ADD  = 3'd1,
		REQ_SUB  = 3'd2,
		REQ_MUL  = 3'd3,
		REQ_DIV  = 3'd4
	} req_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_INSUF    = 2'd1,
		ST_DIVZERO  = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	// controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_LOAD,
		S_ITER,
		S_DONE
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic rd;
		logic load;
		logic step;
		logic commit;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic need_iter;
		logic iter_last;
	} sts_t;

endpackage

/* src/rsa_ram.sv */
`timescale 1ns / 1ps
// generic simple dual-port ram, one write and one read address, registered read
// no dependencies

module rsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* src/rsa_ctrl.sv */
`timescale 1ns / 1ps
// controller state machine for the rpn stack alu
// depends on rsa_pkg

module rsa_ctrl import rsa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	output logic rsp_valid,
	input  logic rsp_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_nxt;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = S_READ;
				end
			end
			S_READ: begin
				cmd.rd    = 1'b1;
				state_nxt = S_LOAD;
			end
			S_LOAD: begin
				cmd.load  = 1'b1;
				state_nxt = sts.need_iter ? S_ITER : S_DONE;
			end
			S_ITER: begin
				cmd.step = 1'b1;
				if (sts.iter_last) begin
					state_nxt = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_nxt  = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	assign rsp_valid = out_valid_q;

	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> (state_q == S_READ))
		else $error("accepted transaction did not start a stack read");

	a_iter_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ITER && !sts.iter_last) |=> (state_q == S_ITER))
		else $error("iterative unit left before its last step");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> rsp_valid)
		else $error("committed result not presented");

endmodule

/* src/rsa_dp.sv */
`timescale 1ns / 1ps
// datapath: stack storage, bit-serial multiply/divide unit, result register
// depends on rsa_pkg and rsa_ram

module rsa_dp import rsa_pkg::*; #(
	parameter int STACK_DEPTH = 16,
	parameter int DATA_WIDTH  = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic [2:0]         req_type,
	input  logic signed [31:0] operand_value,
	output logic [1:0]         status,
	output logic signed [31:0] top_value,
	output logic               is_empty
);

	localparam int IW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(DATA_WIDTH);

	// request registers
	logic [2:0]            req_q;
	logic [DATA_WIDTH-1:0] opnd_q;
	logic [DATA_WIDTH-1:0] push_ext;

	// stack: top entry in a register, the rest in ram
	logic [DATA_WIDTH-1:0] top_q;
	logic [IW-1:0]         top_idx_q;
	logic                  empty_q;
	logic [DATA_WIDTH-1:0] below_rd;

	// iterative unit
	logic [DATA_WIDTH-1:0] acc_q, x_q, y_q;
	logic                  neg_q;
	logic [CW-1:0]         cnt_q;
	logic [DATA_WIDTH:0]   div_t, div_diff;
	logic [DATA_WIDTH-1:0] mag_a, mag_b, result;

	// output registers
	logic [1:0]            status_q;
	logic signed [31:0]    top_value_q;
	logic                  is_empty_q;

	logic                  is_push, is_op, is_mul, is_div;
	logic                  full, few, ok_push, ok_op;
	status_t               code;
	logic [DATA_WIDTH-1:0] nxt_top;
	logic                  nxt_empty;
	logic signed [31:0]    nxt_top32;

	generate
		if (DATA_WIDTH <= 32) begin : g_push_narrow
			assign push_ext = operand_value[DATA_WIDTH-1:0];
		end else begin : g_push_wide
			assign push_ext = {{(DATA_WIDTH-32){operand_value[31]}}, operand_value};
		end
		if (DATA_WIDTH >= 32) begin : g_top_wide
			assign nxt_top32 = nxt_top[31:0];
		end else begin : g_top_narrow
			assign nxt_top32 = {{(32-DATA_WIDTH){nxt_top[DATA_WIDTH-1]}}, nxt_top};
		end
	endgenerate

	// request decode
	always_comb begin
		is_push = 1'b0;
		is_op   = 1'b0;
		is_mul  = 1'b0;
		is_div  = 1'b0;
		unique case (req_q)
			REQ_PUSH: is_push = 1'b1;
			REQ_ADD,
			REQ_SUB:  is_op = 1'b1;
			REQ_MUL: begin
				is_op  = 1'b1;
				is_mul = 1'b1;
			end
			REQ_DIV: begin
				is_op  = 1'b1;
				is_div = 1'b1;
			end
			default: is_op = 1'b0;
		endcase
	end

	assign full = !empty_q && (top_idx_q >= IW'(STACK_DEPTH - 1));
	assign few  = empty_q || (top_idx_q == '0);

	always_comb begin
		priority if (is_push && full) begin
			code = ST_OVERFLOW;
		end else if (is_op && few) begin
			code = ST_INSUF;
		end else if (is_div && (top_q == '0)) begin
			code = ST_DIVZERO;
		end else begin
			code = ST_OK;
		end
	end

	assign ok_push = is_push && (code == ST_OK);
	assign ok_op   = is_op && (code == ST_OK);

	assign sts.need_iter = ok_op && (is_mul || is_div);
	assign sts.iter_last = (cnt_q == '0);

	rsa_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(STACK_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (cmd.commit && ok_push && !empty_q),
		.waddr(top_idx_q),
		.wdata(top_q),
		.re   (cmd.rd),
		.raddr(top_idx_q - IW'(1)),
		.rdata(below_rd)
	);

	assign mag_a    = below_rd[DATA_WIDTH-1] ? (~below_rd + DATA_WIDTH'(1)) : below_rd;
	assign mag_b    = top_q[DATA_WIDTH-1] ? (~top_q + DATA_WIDTH'(1)) : top_q;
	assign div_t    = {acc_q, x_q[DATA_WIDTH-1]};
	assign div_diff = div_t - {1'b0, y_q};
	assign result   = is_div ? (neg_q ? (~x_q + DATA_WIDTH'(1)) : x_q) : acc_q;

	// request capture and iterative unit
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q  <= req_type;
			opnd_q <= push_ext;
		end
		if (cmd.load) begin
			cnt_q <= CW'(DATA_WIDTH - 1);
			neg_q <= below_rd[DATA_WIDTH-1] ^ top_q[DATA_WIDTH-1];
			x_q   <= is_div ? mag_a : below_rd;
			y_q   <= is_div ? mag_b : top_q;
			unique case (req_q)
				REQ_ADD: acc_q <= below_rd + top_q;
				REQ_SUB: acc_q <= below_rd - top_q;
				default: acc_q <= '0;
			endcase
		end else if (cmd.step) begin
			cnt_q <= cnt_q - CW'(1);
			if (is_div) begin
				// restoring step, one quotient bit
				if (!div_diff[DATA_WIDTH]) begin
					acc_q <= div_diff[DATA_WIDTH-1:0];
					x_q   <= {x_q[DATA_WIDTH-2:0], 1'b1};
				end else begin
					acc_q <= div_t[DATA_WIDTH-1:0];
					x_q   <= {x_q[DATA_WIDTH-2:0], 1'b0};
				end
			end else begin
				// shift-add step, low bits only
				if (y_q[0]) begin
					acc_q <= acc_q + x_q;
				end
				x_q <= {x_q[DATA_WIDTH-2:0], 1'b0};
				y_q <= {1'b0, y_q[DATA_WIDTH-1:1]};
			end
		end
	end

	assign nxt_top   = ok_push ? opnd_q : (ok_op ? result : top_q);
	assign nxt_empty = ok_push ? 1'b0 : empty_q;

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			top_q       <= nxt_top;
			status_q    <= code;
			top_value_q <= nxt_empty ? 32'sd0 : nxt_top32;
			is_empty_q  <= nxt_empty;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_idx_q <= '0;
			empty_q   <= 1'b1;
		end else if (cmd.commit) begin
			if (ok_push) begin
				empty_q <= 1'b0;
				if (!empty_q) begin
					top_idx_q <= top_idx_q + IW'(1);
				end
			end else if (ok_op) begin
				top_idx_q <= top_idx_q - IW'(1);
			end
		end
	end

	assign status    = status_q;
	assign top_value = top_value_q;
	assign is_empty  = is_empty_q;

	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && ok_push) |=> !empty_q)
		else $error("stack empty after a good push");

	a_op_pops: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && ok_op) |=> (top_idx_q == $past(top_idx_q) - IW'(1)))
		else $error("operator did not drop one entry");

	a_err_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && !ok_push && !ok_op) |=> ($stable(top_idx_q) && $stable(empty_q)))
		else $error("failed request changed the stack");

endmodule

/* src/rpn_stack_alu.sv */
`timescale 1ns / 1ps
// top level of the rpn stack alu: controller plus datapath
// depends on rsa_pkg, rsa_ctrl, rsa_dp (and rsa_ram below it)

// Reverse Polish integer calculator stack. A request either pushes a signed
// value or applies add, subtract, multiply or divide to the two top entries
// (the lower one is the left operand), replacing them with the result; math
// wraps at DATA_WIDTH bits and division truncates toward zero. Each request
// transaction gives exactly one result transaction with a status (ok,
// insufficient stack, divide by zero, overflow), the top value after the
// step (0 when empty) and an empty flag; a failed request leaves the stack
// as it was. One request is in work at a time. Push, add, subtract, errors
// and unknown codes go through the read, load and done states between
// acceptances; multiply and divide also go through the iterate state of the
// bit-serial shift-add / restoring unit that retires one bit per cycle. The
// top entry lives in a register, the rest of the stack in a dual-port ram
// with registered read, so every operator fetches the entry below the top
// in the read state. A finished result sits in an output register while
// the next request is accepted; completion of that next request waits only
// if the previous result is still stalled. No clearing pass after reset.

module rpn_stack_alu import rsa_pkg::*; #(
	parameter int STACK_DEPTH = 16,
	parameter int DATA_WIDTH  = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	// request channel
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [2:0]         req_type,
	input  logic signed [31:0] operand_value,
	// response channel
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [1:0]         status,
	output logic signed [31:0] top_value,
	output logic               is_empty
);

	cmd_t cmd;
	sts_t sts;

	// sequencing: capture, read, load, iterate, commit
	rsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// stack storage, arithmetic and result register
	rsa_dp #(
		.STACK_DEPTH(STACK_DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.req_type     (req_type),
		.operand_value(operand_value),
		.status       (status),
		.top_value    (top_value),
		.is_empty     (is_empty)
	);

endmodule
